### rtl/cht_pkg.sv
// cht_pkg: types and constants for the counting hash table
// transfer structs for both channels and the stored slot layout; no dependencies

package cht_pkg;

  localparam int KEY_W        = 31;
  localparam int CNT_W        = 32;
  localparam int BUCKETS_DEF  = 1024;
  localparam int SLOTS_DEF    = 8;

  localparam logic             CMD_INC    = 1'b0;
  localparam logic             CMD_REMOVE = 1'b1;
  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] removed_count;
    logic             bucket_full;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

### rtl/counting_hash_table.sv
// counting_hash_table: per-key counts in buckets of key/count slots
// one wide slot memory (one bucket per word) plus a fill-count memory; uses cht_pkg
//
//   channel   signals                 transfer
//   input     start, busy, request    edge with start high and busy low
//   output    done, result            edge ending the cycle with done high
//
// an item passes through bucket read, compare and write back, then the block is idle
// while the result strobe is out; a BUCKETS value that is not a power of two
// adds a reciprocal multiply step, then a multiply back and subtract, ahead of the read.
// after reset busy stays high while the fill memory is swept to zero, one bucket a cycle.
// done is a single-cycle strobe; the receiver cannot stall the block.

module counting_hash_table import cht_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int SLOTS   = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic done,
  output out_t result
);

  localparam int  BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  FILL_W   = $clog2(SLOTS + 1);
  localparam int  POS_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam bit  BKT_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int  REM_SH   = KEY_W + BKT_W;
  localparam int  PROD_W   = KEY_W + 32;
  localparam logic [31:0] RECIP =
    32'(((64'd1 << REM_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_REM   = 3'd6;

  typedef slot_t [SLOTS-1:0] row_t;

  // memories
  row_t              slot_mem [BUCKETS];
  logic [FILL_W-1:0] fill_mem [BUCKETS];

  logic [2:0]        state;
  logic [BKT_W-1:0]  clr_addr;
  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [BKT_W-1:0]  bucket;
  row_t              row_q;
  logic [FILL_W-1:0] fill_q;
  logic              hit_q;
  logic [POS_W-1:0]  pos_q;
  logic [PROD_W-1:0] mod_prod;

  logic              hit_next;
  logic [POS_W-1:0]  pos_next;
  logic [BKT_W-1:0]  mod_quo;
  logic [2*BKT_W-1:0] mod_back;
  logic [BKT_W-1:0]  mod_next;

  row_t              row_dn;
  row_t              row_next;
  logic [CNT_W-1:0]  sel_cnt;
  logic [CNT_W-1:0]  inc_cnt;
  logic              is_full;
  logic              do_insert;
  logic [FILL_W-1:0] fill_next;
  out_t              result_next;

  logic              fill_we;
  logic [BKT_W-1:0]  fill_waddr;
  logic [FILL_W-1:0] fill_wdata;

  assign busy = (state != S_IDLE);

  // remainder from the reciprocal product, low bits only
  always_comb begin
    mod_quo  = mod_prod[REM_SH +: BKT_W];
    mod_back = (2*BKT_W)'(mod_quo) * (2*BKT_W)'(BUCKETS);
    mod_next = key_q[BKT_W-1:0] - mod_back[BKT_W-1:0];
  end

  // compare stage
  always_comb begin
    hit_next = 1'b0;
    pos_next = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((FILL_W'(i) < fill_q) && (row_q[i].key == key_q)) begin
        hit_next = 1'b1;
        pos_next = POS_W'(i);
      end
    end
  end

  // update stage
  always_comb begin
    row_dn    = row_t'(row_q >> SLOT_W);
    sel_cnt   = row_q[pos_q].count;
    inc_cnt   = (sel_cnt == COUNT_MAX) ? sel_cnt : sel_cnt + CNT_W'(1);
    is_full   = (fill_q == FILL_W'(SLOTS));
    do_insert = (cmd_q == CMD_INC) && !hit_q && !is_full;
    fill_next = fill_q;
    if (do_insert) begin
      fill_next = fill_q + FILL_W'(1);
    end else if ((cmd_q == CMD_REMOVE) && hit_q) begin
      fill_next = fill_q - FILL_W'(1);
    end
    for (int i = 0; i < SLOTS; i++) begin
      row_next[i] = row_q[i];
      if ((cmd_q == CMD_INC) && hit_q && (POS_W'(i) == pos_q)) begin
        row_next[i].count = inc_cnt;
      end else if (do_insert && (FILL_W'(i) == fill_q)) begin
        row_next[i].key   = key_q;
        row_next[i].count = CNT_W'(1);
      end else if ((cmd_q == CMD_REMOVE) && hit_q && (POS_W'(i) >= pos_q)) begin
        row_next[i] = row_dn[i];
      end
    end
    result_next.found         = hit_q;
    result_next.removed_count = ((cmd_q == CMD_REMOVE) && hit_q) ? sel_cnt : '0;
    result_next.bucket_full   = (cmd_q == CMD_INC) && !hit_q && is_full;
  end

  // fill memory write port: clearing sweep or update
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = bucket;
    fill_wdata = fill_next;
    if (state == S_CLEAR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_addr;
      fill_wdata = '0;
    end else if (state == S_UPD) begin
      fill_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      fill_q <= fill_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      slot_mem[bucket] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      row_q <= slot_mem[bucket];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + BKT_W'(1);
          if (clr_addr == BKT_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= BKT_POW2 ? S_READ : S_MOD;
          end
        end
        S_MOD:  state <= S_REM;
        S_REM:  state <= S_READ;
        S_READ: state <= S_CMP;
        S_CMP:  state <= S_UPD;
        S_UPD: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q   <= request.command;
          key_q   <= request.key;
          bucket  <= BKT_POW2 ? request.key[BKT_W-1:0] : '0;
        end
      end
      S_MOD: begin
        mod_prod <= PROD_W'(key_q) * PROD_W'(RECIP);
      end
      S_REM: begin
        bucket <= mod_next;
      end
      S_CMP: begin
        hit_q <= hit_next;
        pos_q <= pos_next;
      end
      S_UPD: begin
        result <= result_next;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.bucket_full))
    else $error("full bucket flagged on a hit");

  a_count_hit: assert property (@(posedge clk) disable iff (rst)
    (done && (result.removed_count != '0)) |-> result.found)
    else $error("removed count without a hit");
`endif

endmodule

### sim/tb_counting_hash_table.sv
// tb_counting_hash_table: self-checking bench for the counting hash table
// predicts every outcome with its own bucket/slot table and checks each result strobe
// depends on cht_pkg and counting_hash_table

module tb_counting_hash_table import cht_pkg::*;;

  localparam int BUCKETS    = BUCKETS_DEF;
  localparam int SLOTS      = SLOTS_DEF;
  localparam int CYCLE_CAP  = 300000;
  localparam int RAND_ITEMS = 1400;

  typedef struct {
    in_t req;
    bit  drain;
  } pend_cmd_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  request;
  logic done;
  out_t result;

  pend_cmd_t   command_q[$];
  out_t        table_outcome_q[$];
  logic [KEY_W-1:0] slot_keys   [BUCKETS][SLOTS];
  logic [CNT_W-1:0] slot_counts [BUCKETS][SLOTS];
  int unsigned      fill_cnt    [BUCKETS];
  logic [KEY_W-1:0] pool_key    [4][12];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned gap_left;
  bit          taken;

  counting_hash_table dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_t predict_count(in_t r);
    int unsigned b;
    int unsigned n;
    int unsigned pos;
    bit hit;
    out_t o;
    b = r.key % BUCKETS;
    n = fill_cnt[b];
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < n; i++) begin
      if (!hit && slot_keys[b][i] == r.key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    o = '0;
    o.found = hit;
    if (r.command == CMD_INC) begin
      if (hit) begin
        if (slot_counts[b][pos] != COUNT_MAX) slot_counts[b][pos] = slot_counts[b][pos] + 1;
      end else if (n >= SLOTS) begin
        o.bucket_full = 1'b1;
      end else begin
        slot_keys[b][n]   = r.key;
        slot_counts[b][n] = 1;
        fill_cnt[b]       = n + 1;
      end
    end else if (hit) begin
      o.removed_count = slot_counts[b][pos];
      for (int i = pos; i + 1 < n; i++) begin
        slot_keys[b][i]   = slot_keys[b][i+1];
        slot_counts[b][i] = slot_counts[b][i+1];
      end
      fill_cnt[b] = n - 1;
    end
    return o;
  endfunction

  task automatic queue_cmd(logic cmd, logic [KEY_W-1:0] key, bit drain);
    pend_cmd_t p;
    p.req.command = cmd;
    p.req.key     = key;
    p.drain       = drain;
    command_q.push_back(p);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 6) return pool_key[$urandom_range(0, 3)][$urandom_range(0, 11)];
    if (sel <= 8) return KEY_W'($urandom_range(0, 8191));
    return KEY_W'($urandom);
  endfunction

  // monitor: transfer detection, prediction and result checking
  always @(posedge clk) begin
    out_t exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if ($isunknown(done)) begin
        $display("%0t: done unknown: expected 0 or 1, actual %b", $time, done);
        err_cnt++;
      end else if (done) begin
        if (table_outcome_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual found=%b count=%0d full=%b",
                   $time, result.found, result.removed_count, result.bucket_full);
          err_cnt++;
        end else begin
          exp_r = table_outcome_q.pop_front();
          if (result.found !== exp_r.found) begin
            $display("%0t: found mismatch: expected %b, actual %b",
                     $time, exp_r.found, result.found);
            err_cnt++;
          end
          if (result.removed_count !== exp_r.removed_count) begin
            $display("%0t: removed_count mismatch: expected %0d, actual %0d",
                     $time, exp_r.removed_count, result.removed_count);
            err_cnt++;
          end
          if (result.bucket_full !== exp_r.bucket_full) begin
            $display("%0t: bucket_full mismatch: expected %b, actual %b",
                     $time, exp_r.bucket_full, result.bucket_full);
            err_cnt++;
          end
        end
      end
      taken <= start && (busy === 1'b0);
      if (start && busy === 1'b0) table_outcome_q.push_back(predict_count(request));
    end
  end

  // driver: bursts with random gaps, drain marks hold off until all results are in
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (command_q.size() > 0 &&
                   (!command_q[0].drain || table_outcome_q.size() == 0)) begin
        request <= command_q[0].req;
        void'(command_q.pop_front());
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_CAP);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned hot_b[4];
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    burst_left = 1;
    gap_left   = 0;
    taken      = 1'b0;
    for (int b = 0; b < BUCKETS; b++) fill_cnt[b] = 0;

    // edge keys, hit/remove/absent, then a full bucket with shifts
    queue_cmd(CMD_INC,    31'd0, 1'b0);
    queue_cmd(CMD_INC,    31'h7FFF_FFFF, 1'b0);
    queue_cmd(CMD_INC,    31'h7FFF_FFFF, 1'b0);
    queue_cmd(CMD_REMOVE, 31'h7FFF_FFFF, 1'b0);
    queue_cmd(CMD_REMOVE, 31'h7FFF_FFFF, 1'b0);
    queue_cmd(CMD_REMOVE, 31'd0, 1'b0);
    for (int k = 0; k < SLOTS; k++) queue_cmd(CMD_INC, KEY_W'(5 + k * BUCKETS), 1'b0);
    queue_cmd(CMD_INC,    KEY_W'(5 + 8 * BUCKETS), 1'b0);
    queue_cmd(CMD_INC,    KEY_W'(5 + 2 * BUCKETS), 1'b0);
    queue_cmd(CMD_REMOVE, KEY_W'(5 + 2 * BUCKETS), 1'b0);
    queue_cmd(CMD_INC,    KEY_W'(5 + 7 * BUCKETS), 1'b0);
    queue_cmd(CMD_REMOVE, KEY_W'(5), 1'b0);
    queue_cmd(CMD_INC,    KEY_W'(5 + 8 * BUCKETS), 1'b0);
    queue_cmd(CMD_INC,    KEY_W'(5 + 9 * BUCKETS), 1'b0);
    queue_cmd(CMD_REMOVE, KEY_W'(5 + 8 * BUCKETS), 1'b0);
    queue_cmd(CMD_REMOVE, 31'h2AAA_AAAA, 1'b0);
    queue_cmd(CMD_INC,    31'h5555_5555, 1'b0);

    // hot buckets get more candidate keys than slots so fills, hits and drops all occur
    hot_b[0] = 0;
    hot_b[1] = BUCKETS - 1;
    hot_b[2] = $urandom_range(1, BUCKETS - 2);
    hot_b[3] = $urandom_range(1, BUCKETS - 2);
    for (int h = 0; h < 4; h++)
      for (int t = 0; t < 12; t++)
        pool_key[h][t] = {17'($urandom), 4'(t), 10'(hot_b[h])};

    for (int i = 0; i < RAND_ITEMS; i++)
      queue_cmd(($urandom_range(0, 99) < 65) ? CMD_INC : CMD_REMOVE, pick_key(),
                (i % 350) == 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (command_q.size() > 0 || start) @(posedge clk);
    while (table_outcome_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### counting_hash_table.f
rtl/cht_pkg.sv
rtl/counting_hash_table.sv
sim/tb_counting_hash_table.sv
